// ===== sv/rmp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants of the region mosaic pixelation block.
// ----------------------------------------------------------------------------
package rmp_pkg;

	localparam int POS_W  = 12;
	localparam int SIZE_W = 13;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int BS_W   = 7;
	localparam int REM_W  = 6;
	localparam int CMD_W  = 2;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 13;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 32;

	localparam logic [BS_W-1:0]   BS_MAX      = 7'd64;
	localparam logic [BS_W-1:0]   BS_RESET    = 7'd30;
	localparam logic [CH_W-1:0]   FILL_RESET  = 8'd105;
	localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;

	localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REGION = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [MODE_W-1:0] MODE_MOSAIC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [IDX_W-1:0] REG_MODE  = 4'd0;
	localparam logic [IDX_W-1:0] REG_BLOCK = 4'd1;
	localparam logic [IDX_W-1:0] REG_FILL  = 4'd2;
	localparam logic [IDX_W-1:0] REG_WIDTH = 4'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POS_W-1:0]  region_x;
		logic [POS_W-1:0]  region_y;
		logic [SIZE_W-1:0] region_w;
		logic [SIZE_W-1:0] region_h;
		logic [CH_W-1:0]   blue_in;
		logic [CH_W-1:0]   green_in;
		logic [CH_W-1:0]   red_in;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] red_out;
		logic            masked;
	} result_t;

	// effective settings, already clamped
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BS_W-1:0]   block;
		logic [CH_W-1:0]   fill;
		logic [SIZE_W-1:0] width;
	} cfg_t;

endpackage

// ===== sv/rmp_fifo.sv =====
// ----------------------------------------------------------------------------
// rmp_fifo
// Small register queue with fall-through read data.
// ----------------------------------------------------------------------------
module rmp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/rmp_front.sv =====
// ----------------------------------------------------------------------------
// rmp_front
// Takes commands, keeps the region list and raster position, and classifies
// each pixel against every region.
// ----------------------------------------------------------------------------
module rmp_front #(
	parameter int R = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rmp_pkg::item_t                       item,
	input  logic                                 accept,
	input  rmp_pkg::cfg_t                        cfg,
	output logic                                 pix_push,
	output logic [rmp_pkg::PIX_W-1:0]            pix,
	output logic [R-1:0]                         hit,
	output logic [R-1:0][rmp_pkg::POS_W-1:0]     dx,
	output logic [R-1:0][rmp_pkg::POS_W-1:0]     dy
);
	import rmp_pkg::*;

	localparam int CW = $clog2(R + 1);
	localparam int IW = (R > 1) ? $clog2(R) : 1;

	logic [CW-1:0]     count_q;
	logic [POS_W-1:0]  col_q, row_q;
	logic [POS_W-1:0]  rx_q [R];
	logic [POS_W-1:0]  ry_q [R];
	logic [SIZE_W-1:0] rw_q [R];
	logic [SIZE_W-1:0] rh_q [R];
	logic              add_ok;
	logic              line_end;

	assign add_ok   = accept && (item.command == CMD_REGION) && (count_q < CW'(R));
	assign pix_push = accept && (item.command == CMD_PIXEL);
	assign pix      = {item.red_in, item.green_in, item.blue_in};
	assign line_end = ({1'b0, col_q} + 13'd1) >= cfg.width;

	always_ff @(posedge clk) begin
		if (add_ok) begin
			rx_q[count_q[IW-1:0]] <= item.region_x;
			ry_q[count_q[IW-1:0]] <= item.region_y;
			rw_q[count_q[IW-1:0]] <= item.region_w;
			rh_q[count_q[IW-1:0]] <= item.region_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept && item.command == CMD_FRAME) begin
			count_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (add_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (pix_push) begin
				if (line_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	for (genvar i = 0; i < R; i++) begin : g_lane
		logic in_x, in_y;
		assign in_x = (col_q >= rx_q[i]) &&
			({1'b0, col_q} < ({1'b0, rx_q[i]} + rw_q[i]));
		assign in_y = (row_q >= ry_q[i]) &&
			({1'b0, row_q} < ({1'b0, ry_q[i]} + rh_q[i]));
		assign hit[i] = (CW'(i) < count_q) && in_x && in_y;
		assign dx[i]  = col_q - rx_q[i];
		assign dy[i]  = row_q - ry_q[i];
	end

endmodule

// ===== sv/rmp_back.sv =====
// ----------------------------------------------------------------------------
// rmp_back
// Block grid position by pipelined division, per-region anchor banks and
// output selection.
// ----------------------------------------------------------------------------
module rmp_back #(
	parameter int R   = 8,
	parameter int MBC = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rmp_pkg::cfg_t                    cfg,
	input  logic                             q_empty,
	input  logic [rmp_pkg::PIX_W-1:0]        q_pix,
	input  logic [R-1:0]                     q_hit,
	input  logic [R-1:0][rmp_pkg::POS_W-1:0] q_dx,
	input  logic [R-1:0][rmp_pkg::POS_W-1:0] q_dy,
	output logic                             q_pop,
	input  logic                             out_pop,
	output logic                             out_push,
	output rmp_pkg::result_t                 out_word
);
	import rmp_pkg::*;

	localparam int STG = POS_W;
	localparam int BW  = (MBC > 1) ? $clog2(MBC) : 1;
	localparam int RW  = $clog2(OUT_DEPTH + 1);

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic bit_in, input logic [BS_W-1:0] bs);
		logic [BS_W-1:0] t;
		logic [BS_W-1:0] d;
		t = {rem, bit_in};
		d = t - bs;
		if (t >= bs) begin
			div_step = {1'b1, d[REM_W-1:0]};
		end else begin
			div_step = {1'b0, t[REM_W-1:0]};
		end
	endfunction

	logic [RW-1:0] res_q;

	logic                         vld_q  [STG+1];
	logic [PIX_W-1:0]             pix_q  [STG+1];
	logic [R-1:0]                 hit_q  [STG+1];
	logic [R-1:0][POS_W-1:0]      dxs_q  [STG+1];
	logic [R-1:0][POS_W-1:0]      dys_q  [STG+1];
	logic [R-1:0][POS_W-1:0]      quo_q  [STG+1];
	logic [R-1:0][REM_W-1:0]      crem_q [STG+1];
	logic [R-1:0][REM_W-1:0]      rrem_q [STG+1];

	logic                         vld_m_q;
	logic [PIX_W-1:0]             pix_m_q;
	logic [R-1:0]                 hit_m_q;
	logic [R-1:0]                 wr_m_q;
	logic [R-1:0][PIX_W-1:0]      rd_m_q;

	// room is reserved in the output queue for every word in flight
	assign q_pop = !q_empty && (res_q < RW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (q_pop && !out_pop) begin
			res_q <= res_q + 1'b1;
		end else if (out_pop && !q_pop) begin
			res_q <= res_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		pix_q[0]  <= q_pix;
		hit_q[0]  <= q_hit;
		dxs_q[0]  <= q_dx;
		dys_q[0]  <= q_dy;
		quo_q[0]  <= '0;
		crem_q[0] <= '0;
		rrem_q[0] <= '0;
	end

	for (genvar k = 0; k < STG; k++) begin : g_stage
		logic [R-1:0][REM_W:0] cs, rs;
		for (genvar i = 0; i < R; i++) begin : g_div
			assign cs[i] = div_step(crem_q[k][i], dxs_q[k][i][POS_W-1], cfg.block);
			assign rs[i] = div_step(rrem_q[k][i], dys_q[k][i][POS_W-1], cfg.block);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			pix_q[k+1] <= pix_q[k];
			hit_q[k+1] <= hit_q[k];
			for (int i = 0; i < R; i++) begin
				dxs_q[k+1][i]  <= dxs_q[k][i] << 1;
				dys_q[k+1][i]  <= dys_q[k][i] << 1;
				quo_q[k+1][i]  <= {quo_q[k][i][POS_W-2:0], cs[i][REM_W]};
				crem_q[k+1][i] <= cs[i][REM_W-1:0];
				rrem_q[k+1][i] <= rs[i][REM_W-1:0];
			end
		end
	end

	for (genvar i = 0; i < R; i++) begin : g_bank
		logic [PIX_W-1:0] mem [MBC];
		logic [BW-1:0]    bc;
		logic             wr;

		assign bc = ({1'b0, quo_q[STG][i]} >= (POS_W+1)'(MBC)) ?
			BW'(MBC - 1) : quo_q[STG][i][BW-1:0];
		assign wr = hit_q[STG][i] && (crem_q[STG][i] == '0) && (rrem_q[STG][i] == '0);

		always_ff @(posedge clk) begin
			if (vld_q[STG] && wr) begin
				mem[bc] <= pix_q[STG];
			end
			rd_m_q[i] <= mem[bc];
			wr_m_q[i] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_q <= 1'b0;
		end else begin
			vld_m_q <= vld_q[STG];
		end
	end

	always_ff @(posedge clk) begin
		pix_m_q <= pix_q[STG];
		hit_m_q <= hit_q[STG];
	end

	always_comb begin
		logic [PIX_W-1:0] sel;
		logic             in_region;
		logic [PIX_W-1:0] res;
		sel       = pix_m_q;
		in_region = 1'b0;
		// last loaded region wins; an anchor written now bypasses the bank
		for (int i = 0; i < R; i++) begin
			if (hit_m_q[i]) begin
				in_region = 1'b1;
				sel       = wr_m_q[i] ? pix_m_q : rd_m_q[i];
			end
		end
		if (!in_region) begin
			res = pix_m_q;
		end else if (cfg.mode == MODE_MOSAIC) begin
			res = sel;
		end else if (cfg.mode == MODE_FILL) begin
			res = {cfg.fill, cfg.fill, cfg.fill};
		end else begin
			res = pix_m_q;
		end
		out_word.blue_out  = res[CH_W-1:0];
		out_word.green_out = res[2*CH_W-1:CH_W];
		out_word.red_out   = res[PIX_W-1:2*CH_W];
		out_word.masked    = in_region;
	end

	assign out_push = vld_m_q;

endmodule

// ===== sv/region_mosaic_pixelation.sv =====
// ----------------------------------------------------------------------------
// region_mosaic_pixelation
// Mosaic, gray fill or pass-through of pixels inside loaded region rectangles.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     push / full           item   (rmp_pkg::item_t)
//  result    pop / empty           result (rmp_pkg::result_t)
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while results are popped; a pixel reaches result
// through the middle queue, the 12-stage block position divider, the anchor
// bank read and the output queue. commands other than pixels give no result.
// reset clears the position, region count and all queues; no clearing pass.
// a stalled result side fills the 32-entry output queue, then the 4-entry
// middle queue, then full rises.
// ----------------------------------------------------------------------------
module region_mosaic_pixelation #(
	parameter int MAX_REGIONS    = 8,
	parameter int MAX_BLOCK_COLS = 256,
	parameter int MAX_WIDTH      = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmp_pkg::item_t               item,
	input  logic                         push,
	output logic                         full,
	output rmp_pkg::result_t             result,
	output logic                         empty,
	input  logic                         pop,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rmp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rmp_pkg::DATA_W-1:0]   cfg_data
);
	import rmp_pkg::*;

	localparam int R  = MAX_REGIONS;
	localparam int QW = PIX_W + R * (1 + 2 * POS_W);
	localparam logic [SIZE_W-1:0] WIDTH_INIT =
		(MAX_WIDTH < 640) ? SIZE_W'(MAX_WIDTH) : WIDTH_RESET;

	cfg_t                    cfg_q;
	logic                    accept;
	logic                    pix_push;
	logic [PIX_W-1:0]        f_pix, q_pix;
	logic [R-1:0]            f_hit, q_hit;
	logic [R-1:0][POS_W-1:0] f_dx, f_dy, q_dx, q_dy;
	logic [QW-1:0]           q_rdata;
	logic                    q_empty, q_pop;
	logic                    out_push;
	result_t                 out_word;
	logic                    out_full;
	logic [BS_W-1:0]         bs_in;
	logic [SIZE_W-1:0]       w_in;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign bs_in     = cfg_data[BS_W-1:0];
	assign w_in      = cfg_data[SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_MOSAIC;
			cfg_q.block <= BS_RESET;
			cfg_q.fill  <= FILL_RESET;
			cfg_q.width <= WIDTH_INIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: begin
					cfg_q.mode <= cfg_data[MODE_W-1:0];
				end
				REG_BLOCK: begin
					if (bs_in == '0) begin
						cfg_q.block <= BS_W'(1);
					end else if (bs_in > BS_MAX) begin
						cfg_q.block <= BS_MAX;
					end else begin
						cfg_q.block <= bs_in;
					end
				end
				REG_FILL: begin
					cfg_q.fill <= cfg_data[CH_W-1:0];
				end
				REG_WIDTH: begin
					if (w_in == '0) begin
						cfg_q.width <= SIZE_W'(1);
					end else if ({1'b0, w_in} > (SIZE_W+1)'(MAX_WIDTH)) begin
						cfg_q.width <= SIZE_W'(MAX_WIDTH);
					end else begin
						cfg_q.width <= w_in;
					end
				end
				default: begin
				end
			endcase
		end
	end

	rmp_front #(.R(R)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.cfg      (cfg_q),
		.pix_push (pix_push),
		.pix      (f_pix),
		.hit      (f_hit),
		.dx       (f_dx),
		.dy       (f_dy)
	);

	rmp_fifo #(.WIDTH(QW), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (pix_push),
		.wdata  ({f_pix, f_hit, f_dx, f_dy}),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (full)
	);

	assign {q_pix, q_hit, q_dx, q_dy} = q_rdata;

	rmp_back #(.R(R), .MBC(MAX_BLOCK_COLS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_pix    (q_pix),
		.q_hit    (q_hit),
		.q_dx     (q_dx),
		.q_dy     (q_dy),
		.q_pop    (q_pop),
		.out_pop  (pop && !empty),
		.out_push (out_push),
		.out_word (out_word)
	);

	// never full while a word is pushed: space is reserved before issue
	rmp_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_word),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (out_full)
	);

	logic unused_full;
	assign unused_full = out_full;

endmodule

// ===== sv/rmp_checker.sv =====
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks of the region mosaic pixelation block.
// ----------------------------------------------------------------------------
module rmp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             pop,
	input logic             empty,
	input rmp_pkg::result_t result
);
	import rmp_pkg::*;

	// queues come out of reset empty
	a_rst_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result side not empty in reset");

	a_rst_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("input side full in reset");

	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result word lost");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("waiting result word changed");

endmodule

bind region_mosaic_pixelation rmp_checker u_chk (.*);
